// ===== src/dcrt_pkg.sv =====
// Shared constants and types of the dirty column range tracker
`timescale 1ns / 1ps

package dcrt_pkg;

    localparam int SCREEN_WIDTH  = 400;
    localparam int SCREEN_HEIGHT = 300;
    localparam int MAX_INTERVALS = 8;

    localparam int COL_W  = 9;
    localparam int PMW_W  = 9;
    localparam int GAP_W  = 6;
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int SUM_W  = $clog2(MAX_INTERVALS * SCREEN_WIDTH + 1);
    localparam int ADDR_W = 3;

    localparam logic [2:0] REASON_SINGLE_WIDE  = 3'b001;
    localparam logic [2:0] REASON_TOO_MANY     = 3'b010;
    localparam logic [2:0] REASON_COVERED_WIDE = 3'b100;

    localparam logic REQ_AREA    = 1'b0;
    localparam logic REQ_DISCARD = 1'b1;

    localparam logic KIND_FULL    = 1'b0;
    localparam logic KIND_PARTIAL = 1'b1;

    localparam logic REG_PARTIAL_MAX_WIDTH = 1'b0;
    localparam logic REG_MERGE_GAP         = 1'b1;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [GAP_W-1:0] gap_t;

    typedef struct packed {
        col_t lo;
        col_t hi;
    } span_t;

    // first-hit scan travelling up the row of cells
    typedef struct packed {
        logic  hit;
        span_t span;
    } scan_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic tail;
    } cell_ctl_t;

    typedef struct packed {
        logic merge_en;
        logic append_en;
        logic rotate_en;
    } cell_op_t;

endpackage

// ===== src/dcrt_cell.sv =====
// One interval store cell: overlap test, first-hit scan and tail hand-down
`timescale 1ns / 1ps

module dcrt_cell
    import dcrt_pkg::*;
(
    input  logic      clk,
    input  cell_op_t  op,
    input  cell_ctl_t ctl,
    input  span_t     key,
    input  gap_t      gap,
    input  span_t     nb,
    input  scan_t     scan_in,
    output scan_t     scan_out,
    input  span_t     carry_in,
    output span_t     carry_out,
    output span_t     span
);

    span_t span_reg;
    span_t span_next;
    logic  hit;
    logic  first;
    logic [COL_W:0] own_hi_gap;
    logic [COL_W:0] key_hi_gap;

    assign own_hi_gap = {1'b0, span_reg.hi} + (COL_W + 1)'(gap);
    assign key_hi_gap = {1'b0, key.hi} + (COL_W + 1)'(gap);

    assign hit   = ctl.valid && ({1'b0, key.lo} <= own_hi_gap)
                   && (key_hi_gap >= {1'b0, span_reg.lo});
    assign first = hit && !scan_in.hit;

    assign scan_out.hit  = scan_in.hit || hit;
    assign scan_out.span = first ? span_reg : scan_in.span;

    // last stored entry travels down to the cell that absorbs
    assign carry_out = ctl.last ? span_reg : carry_in;

    always_comb
    begin
        span_next = span_reg;
        if (op.rotate_en)
        begin
            span_next = nb;
        end
        else if (op.merge_en && first)
        begin
            span_next = carry_in;
        end
        else if (op.append_en && ctl.tail)
        begin
            span_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    assign span = span_reg;

endmodule

// ===== src/dirty_column_range_tracker_core.sv =====
// Top level of the dirty column range tracker: sequencer, cell row and APB registers
`timescale 1ns / 1ps

// Takes dirty screen areas one item at a time on the in channel (valid/stall)
// and, at the last area of a frame, gives either one full-refresh result or
// the stored column intervals in store order on the out channel.
// A discard item clears the pending frame state and gives nothing.
// Steps per item: S_IDLE accepts it, S_CHECK clips it, S_MERGE (skipped for
// an invisible or too wide area) absorbs one interval per cycle across the row
// of cells until none hits, and S_FEND checks for frame end. A frame end adds
// S_SUM, which sums the widths as the row makes one full turn, S_DECIDE and
// S_EMIT, which gives the results one by one.
// in_stall is high while an item is being worked on. Results sit in an output
// register; while out_stall is high the register holds and the sequencer waits,
// but once the last result is loaded a new item may be accepted.
// Registers partial_max_width (0x0) and merge_gap (0x4) sit on the APB port
// and must be written by the user only while the block is idle (not enforced).
// Reset empties the store and sets the registers to 200 and 8.
module dirty_column_range_tracker_core
    import dcrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic signed [15:0]  area_x1,
    input  logic signed [15:0]  area_x2,
    input  logic signed [15:0]  area_y1,
    input  logic signed [15:0]  area_y2,
    input  logic                frame_end,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                refresh_kind,
    output logic [8:0]          range_start,
    output logic [8:0]          range_end,
    output logic [2:0]          reason_bits,
    output logic                last_result,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MERGE,
        S_FEND,
        S_SUM,
        S_DECIDE,
        S_EMIT
    } state_t;

    localparam logic signed [15:0] X_MAX = 16'(SCREEN_WIDTH - 1);
    localparam logic signed [15:0] Y_MAX = 16'(SCREEN_HEIGHT - 1);
    localparam col_t               COL_MAX = COL_W'(SCREEN_WIDTH - 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               full_reg, full_next;
    logic [2:0]         reason_reg, reason_next;
    logic signed [15:0] x1_reg, x1_next;
    logic signed [15:0] x2_reg, x2_next;
    logic signed [15:0] y1_reg, y1_next;
    logic signed [15:0] y2_reg, y2_next;
    logic               fend_reg, fend_next;
    span_t              key_reg, key_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PMW_W-1:0]   pmw_reg, pmw_next;
    gap_t               gap_reg, gap_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    col_t               out_start_reg, out_start_next;
    col_t               out_end_reg, out_end_next;
    logic [2:0]         out_reason_reg, out_reason_next;
    logic               out_last_reg, out_last_next;

    cell_op_t  op;
    cell_ctl_t ctl [MAX_INTERVALS];
    span_t     cell_span [MAX_INTERVALS];
    scan_t     scan [MAX_INTERVALS+1];
    span_t     carry [MAX_INTERVALS+1];

    logic               in_accept;
    logic               cfg_write;
    logic               out_free;
    logic               any_hit;
    span_t              hit_span;

    // clipping and alignment
    logic signed [15:0] x1c, x2c, y1c, y2c;
    logic               visible;
    col_t               x1a, x2o, x2a;
    logic [COL_W:0]     span_w;
    logic               span_wide;
    logic [COL_W:0]     cell0_w;
    logic               sum_wide;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || !out_stall;

    assign x1c = (x1_reg < 16'sd0) ? 16'sd0 : x1_reg;
    assign x2c = (x2_reg > X_MAX) ? X_MAX : x2_reg;
    assign y1c = (y1_reg < 16'sd0) ? 16'sd0 : y1_reg;
    assign y2c = (y2_reg > Y_MAX) ? Y_MAX : y2_reg;
    assign visible = (x1c <= x2c) && (y1c <= y2c);

    // when visible both columns lie on screen, so the low bits hold them
    assign x1a = x1c[COL_W-1:0] & ~COL_W'(1);
    assign x2o = x2c[COL_W-1:0] | COL_W'(1);
    assign x2a = (x2o > COL_MAX) ? COL_MAX : x2o;
    assign span_w    = {1'b0, x2a} - {1'b0, x1a} + (COL_W + 1)'(1);
    assign span_wide = span_w >= (COL_W + 1)'(pmw_reg);

    assign cell0_w  = {1'b0, cell_span[0].hi} - {1'b0, cell_span[0].lo}
                      + (COL_W + 1)'(1);
    assign sum_wide = sum_reg >= SUM_W'(pmw_reg);

    // row of cells
    assign scan[0]              = '0;
    assign carry[MAX_INTERVALS] = '0;
    assign any_hit              = scan[MAX_INTERVALS].hit;
    assign hit_span             = scan[MAX_INTERVALS].span;

    assign op.merge_en  = (state_reg == S_MERGE);
    assign op.append_en = (state_reg == S_MERGE) && !any_hit
                          && (count_reg < CNT_W'(MAX_INTERVALS));
    assign op.rotate_en = (state_reg == S_SUM) || ((state_reg == S_EMIT) && out_free);

    for (genvar k = 0; k < MAX_INTERVALS; k++)
    begin : g_cell
        assign ctl[k].valid = CNT_W'(k) < count_reg;
        assign ctl[k].last  = CNT_W'(k + 1) == count_reg;
        assign ctl[k].tail  = CNT_W'(k) == count_reg;

        dcrt_cell u_cell (
            .clk       (clk),
            .op        (op),
            .ctl       (ctl[k]),
            .key       (key_reg),
            .gap       (gap_reg),
            .nb        (cell_span[(k + 1) % MAX_INTERVALS]),
            .scan_in   (scan[k]),
            .scan_out  (scan[k+1]),
            .carry_in  (carry[k+1]),
            .carry_out (carry[k]),
            .span      (cell_span[k])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        full_next       = full_reg;
        reason_next     = reason_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        fend_next       = fend_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        pmw_next        = pmw_reg;
        gap_next        = gap_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_reason_next = out_reason_reg;
        out_last_next   = out_last_reg;

        if (cfg_write)
        begin
            case (paddr[2])
                REG_PARTIAL_MAX_WIDTH: pmw_next = pwdata[PMW_W-1:0];
                REG_MERGE_GAP:         gap_next = pwdata[GAP_W-1:0];
                default:               ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_DISCARD)
                    begin
                        count_next  = '0;
                        full_next   = 1'b0;
                        reason_next = '0;
                    end
                    else
                    begin
                        x1_next    = area_x1;
                        x2_next    = area_x2;
                        y1_next    = area_y1;
                        y2_next    = area_y2;
                        fend_next  = frame_end;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_FEND;
                if (visible)
                begin
                    if (span_wide)
                    begin
                        full_next   = 1'b1;
                        reason_next = reason_reg | REASON_SINGLE_WIDE;
                    end
                    else
                    begin
                        key_next.lo = x1a;
                        key_next.hi = x2a;
                        state_next  = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                if (any_hit)
                begin
                    if (hit_span.lo < key_reg.lo)
                    begin
                        key_next.lo = hit_span.lo;
                    end
                    if (hit_span.hi > key_reg.hi)
                    begin
                        key_next.hi = hit_span.hi;
                    end
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    if (count_reg < CNT_W'(MAX_INTERVALS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        full_next   = 1'b1;
                        reason_next = reason_reg | REASON_TOO_MANY;
                    end
                    state_next = S_FEND;
                end
            end
            S_FEND:
            begin
                if (fend_reg)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM:
            begin
                // a full turn of the row brings the store back into order
                if (idx_reg < count_reg)
                begin
                    sum_next = sum_reg + SUM_W'(cell0_w);
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(MAX_INTERVALS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                idx_next = '0;
                if (full_reg || sum_wide)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_FULL;
                        out_start_next  = '0;
                        out_end_next    = '0;
                        out_reason_next = reason_reg | (sum_wide ? REASON_COVERED_WIDE : 3'b000);
                        out_last_next   = 1'b1;
                        count_next      = '0;
                        full_next       = 1'b0;
                        reason_next     = '0;
                        state_next      = S_IDLE;
                    end
                end
                else if (count_reg == '0)
                begin
                    reason_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_PARTIAL;
                    out_start_next  = cell_span[0].lo;
                    out_end_next    = cell_span[0].hi;
                    out_reason_next = '0;
                    out_last_next   = (idx_reg + CNT_W'(1)) == count_reg;
                    idx_next        = idx_reg + CNT_W'(1);
                    if ((idx_reg + CNT_W'(1)) == count_reg)
                    begin
                        count_next  = '0;
                        full_next   = 1'b0;
                        reason_next = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            full_reg       <= 1'b0;
            reason_reg     <= '0;
            x1_reg         <= '0;
            x2_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            fend_reg       <= 1'b0;
            key_reg        <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            pmw_reg        <= PMW_W'(200);
            gap_reg        <= GAP_W'(8);
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_start_reg  <= '0;
            out_end_reg    <= '0;
            out_reason_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            full_reg       <= full_next;
            reason_reg     <= reason_next;
            x1_reg         <= x1_next;
            x2_reg         <= x2_next;
            y1_reg         <= y1_next;
            y2_reg         <= y2_next;
            fend_reg       <= fend_next;
            key_reg        <= key_next;
            idx_reg        <= idx_next;
            sum_reg        <= sum_next;
            pmw_reg        <= pmw_next;
            gap_reg        <= gap_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_start_reg  <= out_start_next;
            out_end_reg    <= out_end_next;
            out_reason_reg <= out_reason_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign refresh_kind = out_kind_reg;
    assign range_start  = out_start_reg;
    assign range_end    = out_end_reg;
    assign reason_bits  = out_reason_reg;
    assign last_result  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MERGE_GAP) ? 32'(gap_reg) : 32'(pmw_reg);

    // store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_INTERVALS))
        else $error("interval count above store depth");

    // an absorbed interval shrinks the store by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE && any_hit) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("merge did not remove one interval");

    // a new result only comes from the decision or emission steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && out_stall))
        |-> (state_reg == S_DECIDE || state_reg == S_EMIT))
        else $error("result loaded outside emission");

    // full refresh is always the single, final result with an empty range
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_FULL)
        |-> (out_last_reg && out_start_reg == '0 && out_end_reg == '0))
        else $error("malformed full refresh result");

    // after the last result the frame state is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && out_last_reg) |-> (count_reg == '0 && !full_reg))
        else $error("frame state left after last result");

endmodule

// ===== test/tb_dirty_column_range_tracker_core.sv =====
// Self-checking testbench for the dirty column range tracker core
`timescale 1ns / 1ps

module tb_dirty_column_range_tracker_core;
    import dcrt_pkg::*;

    localparam int QUIET_CYCLES = 40;    // longer than the slowest item with no result
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        logic       kind;
        logic [8:0] first_col;
        logic [8:0] last_col;
        logic [2:0] reasons;
        logic       closing;
    } refresh_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [15:0] area_x1;
    logic signed [15:0] area_x2;
    logic signed [15:0] area_y1;
    logic signed [15:0] area_y2;
    logic               frame_end;

    logic       out_valid;
    logic       out_stall;
    logic       refresh_kind;
    logic [8:0] range_start;
    logic [8:0] range_end;
    logic [2:0] reason_bits;
    logic       last_result;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predicted block state
    int       col_lo [MAX_INTERVALS];
    int       col_hi [MAX_INTERVALS];
    int       span_count;
    bit       full_due;
    logic [2:0] reason_acc;
    int       cfg_max_width;
    int       cfg_gap;

    refresh_t due_refreshes[$];
    int       mismatches;
    int       items_sent;
    int       idle_cycles = 0;
    bit       tx_idle;
    bit       rx_idle;
    bit       hold_request;

    dirty_column_range_tracker_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .area_x1      (area_x1),
        .area_x2      (area_x2),
        .area_y1      (area_y1),
        .area_y2      (area_y2),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .refresh_kind (refresh_kind),
        .range_start  (range_start),
        .range_end    (range_end),
        .reason_bits  (reason_bits),
        .last_result  (last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_frame_state();
        span_count = 0;
        full_due   = 1'b0;
        reason_acc = 3'b000;
    endfunction

    // absorbed entries are refilled from the tail and the scan starts over
    function automatic bit absorb_span(input int lo, input int hi);
        int i;
        i = 0;
        while (i < span_count)
        begin
            if (lo <= col_hi[i] + cfg_gap && hi >= col_lo[i] - cfg_gap)
            begin
                if (col_lo[i] < lo) lo = col_lo[i];
                if (col_hi[i] > hi) hi = col_hi[i];
                span_count--;
                col_lo[i] = col_lo[span_count];
                col_hi[i] = col_hi[span_count];
                i = 0;
            end
            else
                i++;
        end
        if (span_count >= MAX_INTERVALS)
            return 1'b0;
        col_lo[span_count] = lo;
        col_hi[span_count] = hi;
        span_count++;
        return 1'b1;
    endfunction

    function automatic void predict_refresh(input logic kind_in,
                                            input logic signed [15:0] ax1,
                                            input logic signed [15:0] ax2,
                                            input logic signed [15:0] ay1,
                                            input logic signed [15:0] ay2,
                                            input logic closing);
        int x1, x2, y1, y2, covered;
        bit wide;
        refresh_t r;
        if (kind_in == REQ_DISCARD)
        begin
            clear_frame_state();
            return;
        end
        x1 = int'(ax1);
        x2 = int'(ax2);
        y1 = int'(ay1);
        y2 = int'(ay2);
        if (x1 < 0) x1 = 0;
        if (x2 > SCREEN_WIDTH - 1) x2 = SCREEN_WIDTH - 1;
        if (y1 < 0) y1 = 0;
        if (y2 > SCREEN_HEIGHT - 1) y2 = SCREEN_HEIGHT - 1;
        if (x1 <= x2 && y1 <= y2)
        begin
            x1 = x1 & ~1;
            x2 = x2 | 1;
            if (x2 > SCREEN_WIDTH - 1) x2 = SCREEN_WIDTH - 1;
            if (x2 - x1 + 1 >= cfg_max_width)
            begin
                full_due   = 1'b1;
                reason_acc = reason_acc | REASON_SINGLE_WIDE;
            end
            else if (!absorb_span(x1, x2))
            begin
                full_due   = 1'b1;
                reason_acc = reason_acc | REASON_TOO_MANY;
            end
        end
        if (closing)
        begin
            covered = 0;
            for (int i = 0; i < span_count; i++)
                covered += col_hi[i] - col_lo[i] + 1;
            wide = (covered >= cfg_max_width);
            if (wide) reason_acc = reason_acc | REASON_COVERED_WIDE;
            if (full_due || wide)
            begin
                r.kind      = KIND_FULL;
                r.first_col = '0;
                r.last_col  = '0;
                r.reasons   = reason_acc;
                r.closing   = 1'b1;
                due_refreshes.push_back(r);
            end
            else
            begin
                for (int i = 0; i < span_count; i++)
                begin
                    r.kind      = KIND_PARTIAL;
                    r.first_col = col_lo[i][8:0];
                    r.last_col  = col_hi[i][8:0];
                    r.reasons   = 3'b000;
                    r.closing   = (i + 1 == span_count);
                    due_refreshes.push_back(r);
                end
            end
            clear_frame_state();
        end
    endfunction

    function automatic void flag_mismatch(input string what, input refresh_t want,
                                          input refresh_t got);
        if (mismatches < 10)
            $display("%0t %s: kind %0d/%0d start %0d/%0d end %0d/%0d reasons %0d/%0d last %0d/%0d",
                     $realtime, what, want.kind, got.kind, want.first_col, got.first_col,
                     want.last_col, got.last_col, want.reasons, got.reasons,
                     want.closing, got.closing);
        mismatches++;
    endfunction

    // result checker (expected/actual)
    always @(posedge clk)
    begin
        refresh_t got;
        refresh_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind      = refresh_kind;
            got.first_col = range_start;
            got.last_col  = range_end;
            got.reasons   = reason_bits;
            got.closing   = last_result;
            if (due_refreshes.size() == 0)
            begin
                want = '{default: '0};
                flag_mismatch("result with none expected", want, got);
            end
            else
            begin
                want = due_refreshes.pop_front();
                if (got.kind !== want.kind || got.first_col !== want.first_col ||
                    got.last_col !== want.last_col || got.reasons !== want.reasons ||
                    got.closing !== want.closing)
                    flag_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver: short random stalls per result, plus an occasional long hold
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                stall_left = rx_idle ? $urandom_range(0, 3) : 0;
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // leaves in_valid high so a back-to-back item needs no second assignment
    task automatic send_item(input logic kind_in, input int x1, input int x2,
                             input int y1, input int y2, input logic closing);
        int pause;
        pause = tx_idle ? $urandom_range(0, 3) : 0;
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind_in;
        area_x1   <= 16'(x1);
        area_x2   <= 16'(x2);
        area_y1   <= 16'(y1);
        area_y2   <= 16'(y2);
        frame_end <= closing;
        do
            @(posedge clk);
        while (in_stall);
        predict_refresh(kind_in, 16'(x1), 16'(x2), 16'(y1), 16'(y2), closing);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (due_refreshes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PARTIAL_MAX_WIDTH)
            cfg_max_width = value & 9'h1FF;
        else
            cfg_gap = value & 6'h3F;
    endtask

    task automatic set_config(input int max_width, input int gap);
        wait_drain();
        write_reg(REG_PARTIAL_MAX_WIDTH, max_width);
        write_reg(REG_MERGE_GAP, gap);
    endtask

    task automatic send_random_item(input logic closing);
        int x1, x2, y1, y2;
        logic kind_in, fe;
        int pick;
        pick    = $urandom_range(0, 99);
        kind_in = REQ_AREA;
        fe      = closing;
        x1 = $urandom_range(0, SCREEN_WIDTH - 1);
        y1 = $urandom_range(0, SCREEN_HEIGHT - 1);
        y2 = y1 + $urandom_range(0, 40);
        x2 = x1 + $urandom_range(0, 30);
        if (pick < 55)
            ;
        else if (pick < 70)
            x2 = x1 + $urandom_range(31, 460);
        else if (pick < 78)
        begin
            // straddles the left edge
            x1 = x1 - 200;
            x2 = x1 + $urandom_range(0, 300);
        end
        else if (pick < 86)
        begin
            x1 = $urandom;
            x2 = $urandom;
            y1 = $urandom;
            y2 = $urandom;
        end
        else if (pick < 92)
            y2 = -1 - $urandom_range(0, 100);
        else if (pick < 96)
        begin
            kind_in = REQ_DISCARD;
            x1 = $urandom;
            x2 = $urandom;
            y1 = $urandom;
            y2 = $urandom;
            fe = 1'($urandom_range(0, 1));
        end
        else
            fe = 1'b1;
        send_item(kind_in, x1, x2, y1, y2, fe);
    endtask

    task automatic test_directed_frames();
        // two merged spans, one clamped at the right edge
        send_item(REQ_AREA, 10, 20, 0, 0, 1'b0);
        send_item(REQ_AREA, 25, 30, 5, 5, 1'b0);
        send_item(REQ_AREA, 398, 32767, -32768, 32767, 1'b1);
        // whole field range is one wide span
        send_item(REQ_AREA, -32768, 32767, -32768, 32767, 1'b1);
        // nothing visible, frame end on an off-screen area: empty frame
        send_item(REQ_AREA, 50, 60, 300, 400, 1'b0);
        send_item(REQ_AREA, 400, 32767, 0, 10, 1'b1);
        // store overflow
        for (int i = 0; i < MAX_INTERVALS; i++)
            send_item(REQ_AREA, i * 48, i * 48 + 3, 0, 0, 1'b0);
        send_item(REQ_AREA, 390, 393, 0, 0, 1'b1);
        // discard with frame end set gives nothing
        send_item(REQ_AREA, 0, 5, 0, 0, 1'b0);
        send_item(REQ_DISCARD, -1, -1, -1, -1, 1'b1);
        // summed width too large
        send_item(REQ_AREA, 0, 150, 0, 0, 1'b0);
        send_item(REQ_AREA, 200, 260, 0, 299, 1'b1);
        // full store emitted as partial ranges
        for (int i = 0; i < MAX_INTERVALS; i++)
            send_item(REQ_AREA, i * 50 + 1, i * 50 + 2, 299, 299, i == MAX_INTERVALS - 1);
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        int n_areas;
        int frames;
        stop_at = items_sent + n_items;
        frames  = 0;
        while (items_sent < stop_at)
        begin
            n_areas = $urandom_range(1, 9);
            for (int k = 0; k < n_areas; k++)
                send_random_item(k == n_areas - 1);
            frames++;
            if (frames % 7 == 0)
                wait_drain();    // let the sender go quiet until all is out
        end
    endtask

    task automatic test_output_hold();
        tx_idle      = 1'b0;
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++)
            send_random_item($urandom_range(0, 2) == 0);
        wait_drain();
        tx_idle = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req_type  <= REQ_AREA;
        area_x1   <= '0;
        area_x2   <= '0;
        area_y1   <= '0;
        area_y2   <= '0;
        frame_end <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        mismatches    = 0;
        items_sent    = 0;
        hold_request  = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        cfg_max_width = 200;
        cfg_gap       = 8;
        clear_frame_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_traffic(50);
        set_config(400, 0);
        test_random_traffic(60);
        set_config(511, 63);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_traffic(60);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_config(0, 5);
        test_random_traffic(20);
        set_config(1, 0);
        test_random_traffic(15);
        set_config(120, 20);
        test_output_hold();
        test_random_traffic(40);
        wait_drain();

        if (mismatches == 0 && due_refreshes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
